// ----- design/routing_lookahead_cost_query_macros.svh -----
// ----------------------------------------------------------------------------
// Routing lookahead cost query: assertion macros
// Shared concurrent assertion forms used by the block's RTL.
// ----------------------------------------------------------------------------
`ifndef ROUTING_LOOKAHEAD_COST_QUERY_MACROS_SVH
`define ROUTING_LOOKAHEAD_COST_QUERY_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RLCQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define RLCQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rlcq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcq_pkg
// Types, codes and constants shared by the lookahead cost query block.
// ----------------------------------------------------------------------------
package rlcq_pkg;

   localparam int GRID_W_DEF         = 64;
   localparam int GRID_H_DEF         = 64;
   localparam int SEG_TYPE_COUNT_DEF = 4;

   localparam int QUEUE_DEPTH = 4;
   localparam int COORD_W     = 6;
   localparam int CRIT_W      = 17;
   localparam int WORD_W      = 32;

   localparam logic [CRIT_W-1:0] ONE_Q16 = 17'd65536;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [1:0] DIR_INC = 2'd0;
   localparam logic [1:0] DIR_DEC = 2'd1;

   // one command handed from the front end to the back end
   typedef struct packed {
      logic                 is_load;
      logic [CRIT_W-1:0]    crit;
      logic [COORD_W-1:0]   dx;
      logic [COORD_W-1:0]   dy;
      logic [2*WORD_W-1:0]  data;
   } cmd_type;

   function automatic int idx_w(input int n);
      idx_w = (n > 1) ? $clog2(n) : 1;
   endfunction

   // table address = {chany, seg, dx, dy}
   function automatic int addr_w(input int gw, input int gh, input int ns);
      addr_w = 1 + idx_w(ns) + idx_w(gw) + idx_w(gh);
   endfunction

endpackage

// ----- design/routing_lookahead_cost_query.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// routing_lookahead_cost_query
// Lookahead cost table with load and blended-cost query on one channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer. mode 0 loads entry_data into the
//   table at (chany, seg_type, to_x, to_y); loads outside the table are
//   dropped and no load gives a response. mode 1 is a query: offsets are
//   computed from the wire span and target, saturated to the grid, and the
//   entry is blended by criticality.
//   rsp_* carries one response per query, in request order.
//   Throughput: one item per cycle while rsp_ready keeps the back end moving.
//   A query transfer passes the front register, command queue, table read,
//   multiply and output register before it shows on rsp_valid.
//   The table memory has one port, used by one queued command per cycle.
//   A stalled rsp_ready backs up the back end; the four-entry command queue
//   and the front register absorb items, then req_ready drops. Loads still
//   retire while the response stage is full.
//   Reset clears control state only; table contents stay undefined until
//   loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
`include "routing_lookahead_cost_query_macros.svh"

module routing_lookahead_cost_query #(
   parameter int GRID_W         = rlcq_pkg::GRID_W_DEF,
   parameter int GRID_H         = rlcq_pkg::GRID_H_DEF,
   parameter int SEG_TYPE_COUNT = rlcq_pkg::SEG_TYPE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic        req_from_is_chany,
   input  logic [1:0]  req_seg_type,
   input  logic [5:0]  req_from_xlow,
   input  logic [5:0]  req_from_xhigh,
   input  logic [5:0]  req_from_ylow,
   input  logic [5:0]  req_from_yhigh,
   input  logic [1:0]  req_from_direction,
   input  logic [5:0]  req_to_x,
   input  logic [5:0]  req_to_y,
   input  logic [16:0] req_criticality,
   input  logic [63:0] req_entry_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_lookahead_cost,
   output logic [5:0]  rsp_delta_x_out,
   output logic [5:0]  rsp_delta_y_out
);
   import rlcq_pkg::*;

   localparam int ADDR_W  = addr_w(GRID_W, GRID_H, SEG_TYPE_COUNT);
   localparam int ENTRY_W = ADDR_W + $bits(cmd_type);

   logic              q_push, q_pop, q_full, q_empty;
   logic [ADDR_W-1:0] push_addr, head_addr;
   cmd_type           push_cmd, head_cmd;
   logic [ENTRY_W-1:0] head_entry;

   rlcq_front #(
      .GRID_W         (GRID_W),
      .GRID_H         (GRID_H),
      .SEG_TYPE_COUNT (SEG_TYPE_COUNT),
      .ADDR_W         (ADDR_W)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_from_is_chany  (req_from_is_chany),
      .req_seg_type       (req_seg_type),
      .req_from_xlow      (req_from_xlow),
      .req_from_xhigh     (req_from_xhigh),
      .req_from_ylow      (req_from_ylow),
      .req_from_yhigh     (req_from_yhigh),
      .req_from_direction (req_from_direction),
      .req_to_x           (req_to_x),
      .req_to_y           (req_to_y),
      .req_criticality    (req_criticality),
      .req_entry_data     (req_entry_data),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_addr             (push_addr),
      .q_cmd              (push_cmd)
   );

   rlcq_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_addr, push_cmd}),
      .pop       (q_pop),
      .head_data (head_entry),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign head_addr = head_entry[ENTRY_W-1 -: ADDR_W];
   assign head_cmd  = head_entry[$bits(cmd_type)-1:0];

   rlcq_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_addr             (head_addr),
      .q_cmd              (head_cmd),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_lookahead_cost (rsp_lookahead_cost),
      .rsp_delta_x_out    (rsp_delta_x_out),
      .rsp_delta_y_out    (rsp_delta_y_out)
   );

   `RLCQ_ASSERT_SAME(a_no_push_when_full, clock, reset, q_push, !q_full, "push into full queue")
   `RLCQ_ASSERT_SAME(a_no_pop_when_empty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `RLCQ_ASSERT_NEXT(a_push_lands, clock, reset, q_push, !q_empty, "pushed command lost")

endmodule

// ----- design/rlcq_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcq_front
// Accepts items, works out table offsets and address, registers one command.
// ----------------------------------------------------------------------------
module rlcq_front #(
   parameter int GRID_W         = 64,
   parameter int GRID_H         = 64,
   parameter int SEG_TYPE_COUNT = 4,
   parameter int ADDR_W         = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic                  req_from_is_chany,
   input  logic [1:0]            req_seg_type,
   input  logic [5:0]            req_from_xlow,
   input  logic [5:0]            req_from_xhigh,
   input  logic [5:0]            req_from_ylow,
   input  logic [5:0]            req_from_yhigh,
   input  logic [1:0]            req_from_direction,
   input  logic [5:0]            req_to_x,
   input  logic [5:0]            req_to_y,
   input  logic [16:0]           req_criticality,
   input  logic [63:0]           req_entry_data,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [ADDR_W-1:0]     q_addr,
   output rlcq_pkg::cmd_type     q_cmd
);
   import rlcq_pkg::*;

   localparam int SW   = idx_w(SEG_TYPE_COUNT);
   localparam int XW   = idx_w(GRID_W);
   localparam int YW   = idx_w(GRID_H);
   localparam int XMAX = GRID_W - 1;
   localparam int YMAX = GRID_H - 1;

   logic              f_valid_ff, f_valid_in;
   logic [ADDR_W-1:0] f_addr_ff, f_addr_in;
   cmd_type           f_cmd_ff, f_cmd_in;

   logic              accept;
   logic [5:0]        seg_low, seg_high, chan, to_seg, to_chan;
   logic [6:0]        d_chan, d_seg, dx, dy, dx_sat, dy_sat;
   logic              skip, load_ok;
   logic [SW-1:0]     seg_idx;
   logic [16:0]       crit_sat;

   assign req_ready = !f_valid_ff || !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (req_from_is_chany) begin
         seg_low  = req_from_ylow;
         seg_high = req_from_yhigh;
         chan     = req_from_xlow;
         to_seg   = req_to_y;
         to_chan  = req_to_x;
      end else begin
         seg_low  = req_from_xlow;
         seg_high = req_from_xhigh;
         chan     = req_from_ylow;
         to_seg   = req_to_x;
         to_chan  = req_to_y;
      end

      // across the wire: targets right next to the channel cost nothing
      if ({1'b0, to_chan} > {1'b0, chan} + 7'd1) begin
         d_chan = {1'b0, to_chan} - {1'b0, chan};
         skip   = 1'b1;
      end else if (to_chan < chan) begin
         d_chan = {1'b0, chan} - {1'b0, to_chan} + 7'd1;
         skip   = 1'b1;
      end else begin
         d_chan = 7'd0;
         skip   = 1'b0;
      end

      // along the wire; the difference is at least one, so never negative
      if (to_seg > seg_high) begin
         d_seg = {1'b0, to_seg} - {1'b0, seg_high} - {6'd0, skip};
      end else if (to_seg < seg_low) begin
         d_seg = {1'b0, seg_low} - {1'b0, to_seg} - {6'd0, skip};
      end else begin
         d_seg = 7'd0;
      end
      // extra step when the target lies behind a directional wire
      if ((to_seg < seg_low && req_from_direction == DIR_INC) ||
          (to_seg > seg_high && req_from_direction == DIR_DEC)) begin
         d_seg = d_seg + 7'd1;
      end

      dx     = req_from_is_chany ? d_chan : d_seg;
      dy     = req_from_is_chany ? d_seg : d_chan;
      dx_sat = (int'(dx) > XMAX) ? 7'(XMAX) : dx;
      dy_sat = (int'(dy) > YMAX) ? 7'(YMAX) : dy;

      seg_idx  = (int'(req_seg_type) >= SEG_TYPE_COUNT) ? SW'(SEG_TYPE_COUNT - 1)
                                                         : SW'(req_seg_type);
      crit_sat = (req_criticality > ONE_Q16) ? ONE_Q16 : req_criticality;
      load_ok  = (int'(req_seg_type) < SEG_TYPE_COUNT) && (int'(req_to_x) < GRID_W) &&
                 (int'(req_to_y) < GRID_H);

      f_cmd_in.is_load = (req_mode == MODE_LOAD);
      f_cmd_in.crit    = crit_sat;
      f_cmd_in.dx      = dx_sat[5:0];
      f_cmd_in.dy      = dy_sat[5:0];
      f_cmd_in.data    = req_entry_data;
      if (req_mode == MODE_LOAD) begin
         f_addr_in = {req_from_is_chany, SW'(req_seg_type), XW'(req_to_x), YW'(req_to_y)};
      end else begin
         f_addr_in = {req_from_is_chany, seg_idx, XW'(dx_sat), YW'(dy_sat)};
      end

      // loads outside the table are dropped here
      if (accept) begin
         f_valid_in = (req_mode == MODE_QUERY) || load_ok;
      end else if (q_push) begin
         f_valid_in = 1'b0;
      end else begin
         f_valid_in = f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_addr_ff <= f_addr_in;
         f_cmd_ff  <= f_cmd_in;
      end
   end

   assign q_push = f_valid_ff && !q_full;
   assign q_addr = f_addr_ff;
   assign q_cmd  = f_cmd_ff;

endmodule

// ----- design/rlcq_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcq_queue
// Short command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module rlcq_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] head_data,
   output logic              full,
   output logic              empty
);
   import rlcq_pkg::*;

   localparam int PW = idx_w(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign full      = (int'(count_ff) == QUEUE_DEPTH);
   assign empty     = (count_ff == '0);

endmodule

// ----- design/rlcq_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlcq_back
// Cost table memory, criticality blend and output register.
// ----------------------------------------------------------------------------
module rlcq_back #(
   parameter int ADDR_W = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  logic [ADDR_W-1:0]     q_addr,
   input  rlcq_pkg::cmd_type     q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_lookahead_cost,
   output logic [5:0]            rsp_delta_x_out,
   output logic [5:0]            rsp_delta_y_out
);
   import rlcq_pkg::*;

   localparam int DEPTH  = 1 << ADDR_W;
   localparam int PROD_W = CRIT_W + WORD_W;

   logic [2*WORD_W-1:0] cost_mem_ff [DEPTH];

   // stage 1: table read
   logic                s1_valid_ff, s1_valid_in;
   logic [2*WORD_W-1:0] s1_entry_ff;
   logic [CRIT_W-1:0]   s1_crit_ff;
   logic [5:0]          s1_dx_ff, s1_dy_ff;
   // stage 2: weighted products
   logic                s2_valid_ff, s2_valid_in;
   logic [PROD_W-1:0]   s2_pdel_ff, s2_pcong_ff;
   logic [5:0]          s2_dx_ff, s2_dy_ff;
   // stage 3: output register
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         out_cost_ff;
   logic [5:0]          out_dx_ff, out_dy_ff;

   logic                out_adv, s2_adv, s1_adv;
   logic                wr_en, rd_en;
   logic [PROD_W:0]     blend_sum;

   assign out_adv   = !out_valid_ff || rsp_ready;
   assign s2_adv    = !s2_valid_ff || out_adv;
   assign s1_adv    = !s1_valid_ff || s2_adv;
   // loads retire at the head without needing downstream room
   assign q_pop     = !q_empty && (q_cmd.is_load || s1_adv);
   assign wr_en     = q_pop && q_cmd.is_load;
   assign rd_en     = q_pop && !q_cmd.is_load;
   assign blend_sum = {1'b0, s2_pdel_ff} + {1'b0, s2_pcong_ff};

   always_comb begin
      s1_valid_in  = s1_adv ? rd_en : s1_valid_ff;
      s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
      out_valid_in = out_adv ? s2_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cost_mem_ff[q_addr] <= q_cmd.data;
      end
      if (rd_en) begin
         s1_entry_ff <= cost_mem_ff[q_addr];
         s1_crit_ff  <= q_cmd.crit;
         s1_dx_ff    <= q_cmd.dx;
         s1_dy_ff    <= q_cmd.dy;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s1_valid_ff) begin
         s2_pdel_ff  <= PROD_W'(s1_crit_ff) * PROD_W'(s1_entry_ff[2*WORD_W-1:WORD_W]);
         s2_pcong_ff <= PROD_W'(ONE_Q16 - s1_crit_ff) * PROD_W'(s1_entry_ff[WORD_W-1:0]);
         s2_dx_ff    <= s1_dx_ff;
         s2_dy_ff    <= s1_dy_ff;
      end
      if (out_adv && s2_valid_ff) begin
         out_cost_ff <= blend_sum[47:16];
         out_dx_ff   <= s2_dx_ff;
         out_dy_ff   <= s2_dy_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_lookahead_cost = out_cost_ff;
   assign rsp_delta_x_out    = out_dx_ff;
   assign rsp_delta_y_out    = out_dy_ff;

endmodule
